[src/wdc_pkg.sv]
// Shared types, constants and the arctangent table of the waypoint drive controller.
// No dependencies; used by every module in src.
package wdc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 7;
    localparam int XW            = 36;
    localparam int ZW            = 26;
    localparam int DW            = 17;
    localparam int CFG_DW        = 14;
    localparam int CFG_IW        = 3;

    localparam logic [CFG_IW-1:0] CFG_POS_TOL   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_HEAD_TOL  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_AIM_TOL   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TRANS_SCL = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ROT_GAIN  = 3'd4;

    localparam logic signed [ZW-1:0] QUARTER_Z = 26'sd4194304;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [15:0]   th;
        logic signed [15:0]   rh;
    } t_side;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_side                side;
    } t_cell;

    typedef enum logic [3:0] {
        MODE_NONE   = 4'b0001,
        MODE_ROT    = 4'b0010,
        MODE_DRIVE  = 4'b0100,
        MODE_ARRIVE = 4'b1000
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  neg;
        logic  back;
    } t_ctl;

    typedef struct packed {
        logic [11:0] pos_tol;
        logic [13:0] head_tol;
        logic [13:0] aim_tol;
        logic [9:0]  trans_scale;
        logic [10:0] rot_gain;
    } t_cfg;

    function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        v = '0;
        unique case (idx)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            5'd20: v = 26'sd3;
            5'd21: v = 26'sd1;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/wdc_cordic_cell.sv]
// One vectoring CORDIC iteration with its pose side data.
// Depends on wdc_pkg.
module wdc_cordic_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_stage,
    input  wdc_pkg::t_cell      i_cell,
    output wdc_pkg::t_cell      o_cell
);
    wdc_pkg::t_cell r_cell;
    wdc_pkg::t_cell n_cell;
    logic signed [wdc_pkg::XW-1:0] xs;
    logic signed [wdc_pkg::XW-1:0] ys;

    always_comb begin
        xs     = i_cell.x >>> i_stage;
        ys     = i_cell.y >>> i_stage;
        n_cell = i_cell;
        if (i_cell.y > 0) begin
            n_cell.x = i_cell.x + ys;
            n_cell.y = i_cell.y - xs;
            n_cell.z = i_cell.z + wdc_pkg::atan_at(i_stage);
        end else begin
            n_cell.x = i_cell.x - ys;
            n_cell.y = i_cell.y + xs;
            n_cell.z = i_cell.z - wdc_pkg::atan_at(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell.x    <= n_cell.x;
        r_cell.y    <= n_cell.y;
        r_cell.z    <= n_cell.z;
        r_cell.side <= n_cell.side;
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
    end

    assign o_cell = r_cell;
endmodule

[src/wdc_post.sv]
// Heading error, mode choice, gain and speed arithmetic after the CORDIC chain.
// Depends on wdc_pkg.
module wdc_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wdc_pkg::t_cell       i_cell,
    input  wdc_pkg::t_cfg        i_cfg,
    output logic                 o_done,
    output logic signed [10:0]   o_left_wheel,
    output logic signed [10:0]   o_right_wheel,
    output logic                 o_command_valid,
    output logic                 o_arrived
);
    // P1
    logic        r1_valid, r1_in_pos;
    logic signed [15:0] r1_dn;
    logic [33:0] r1_sqx, r1_sqy;
    logic [16:0] adx, ady;
    logic signed [wdc_pkg::ZW-1:0] zr;
    logic signed [15:0] bear, nom;
    // P2
    wdc_pkg::t_ctl r2_ctl, r3_ctl, r4_ctl, r5_ctl;
    wdc_pkg::t_ctl n2_ctl;
    logic [16:0] r2_m;
    logic [5:0]  r2_gain, r2_f;
    logic signed [15:0] db;
    logic [16:0] adn, adb, m;
    logic [33:0] d2;
    logic [5:0]  gain, f;
    // P3..P5
    logic [22:0] r3_p1;
    logic [15:0] r3_tv;
    logic [33:0] r4_m2;
    logic [8:0]  r4_tr, r5_tr;
    logic [27:0] trp;
    logic [16:0] s;
    logic [33:0] sq;
    logic [11:0] r5_q;
    // P6
    logic signed [12:0] d, trs, lw, rw;
    logic signed [10:0] lsat, rsat;

    always_comb begin
        adx  = i_cell.side.dx < 0 ? 17'(-i_cell.side.dx) : 17'(i_cell.side.dx);
        ady  = i_cell.side.dy < 0 ? 17'(-i_cell.side.dy) : 17'(i_cell.side.dy);
        zr   = i_cell.z + wdc_pkg::ZW'(128);
        bear = (i_cell.side.dx == 0 && i_cell.side.dy == 0) ? 16'sd0 : zr[23:8];
        nom  = (adx < {5'd0, i_cfg.pos_tol} && ady < {5'd0, i_cfg.pos_tol})
               ? i_cell.side.th : bear;
    end

    always_ff @(posedge i_clk) begin
        r1_in_pos <= adx < {5'd0, i_cfg.pos_tol} && ady < {5'd0, i_cfg.pos_tol};
        r1_dn     <= nom - i_cell.side.rh;
        r1_sqx    <= 34'(i_cell.side.dx * i_cell.side.dx);
        r1_sqy    <= 34'(i_cell.side.dy * i_cell.side.dy);
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_cell.valid;
        end
    end

    always_comb begin
        db   = r1_dn ^ 16'sh8000;
        adn  = r1_dn < 0 ? 17'(-17'(r1_dn)) : 17'(r1_dn);
        adb  = db < 0 ? 17'(-17'(db)) : 17'(db);
        n2_ctl.valid = r1_valid;
        n2_ctl.back  = adn > adb;
        n2_ctl.neg   = n2_ctl.back ? db[15] : r1_dn[15];
        m    = n2_ctl.back ? adb : adn;
        if (m < 17'd3459 || m > 17'd29309) begin
            gain = 6'd40;
        end else if (m < 17'd5462 || m > 17'd27306) begin
            gain = 6'd28;
        end else begin
            gain = 6'd19;
        end
        n2_ctl.mode = wdc_pkg::MODE_NONE;
        if (r1_in_pos) begin
            n2_ctl.mode = (m > {3'd0, i_cfg.head_tol}) ? wdc_pkg::MODE_ROT
                                                       : wdc_pkg::MODE_ARRIVE;
        end else if (m > {3'd0, i_cfg.aim_tol} && m < 17'd16384) begin
            n2_ctl.mode = wdc_pkg::MODE_ROT;
        end else if (m <= {3'd0, i_cfg.aim_tol}) begin
            n2_ctl.mode = wdc_pkg::MODE_DRIVE;
            gain = (m < 17'd1821) ? 6'd12 : 6'd18;
        end
        d2 = r1_sqx + r1_sqy;
        if (40'(d2) * 40'd25 > 40'd16777216) begin
            f = 6'd34;
        end else if (40'(d2) * 40'd625 > 40'd150994944) begin
            f = 6'd17;
        end else begin
            f = 6'd9;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ctl.mode <= n2_ctl.mode;
        r2_ctl.neg  <= n2_ctl.neg;
        r2_ctl.back <= n2_ctl.back;
        r2_m    <= m;
        r2_gain <= gain;
        r2_f    <= f;
        r3_ctl.mode <= r2_ctl.mode;
        r3_ctl.neg  <= r2_ctl.neg;
        r3_ctl.back <= r2_ctl.back;
        r3_p1   <= 23'(r2_m * r2_gain);
        r3_tv   <= 16'(i_cfg.trans_scale * r2_f) + 16'd50;
        r4_ctl.mode <= r3_ctl.mode;
        r4_ctl.neg  <= r3_ctl.neg;
        r4_ctl.back <= r3_ctl.back;
        r4_m2   <= 34'(r3_p1 * i_cfg.rot_gain);
        r4_tr   <= trp[27:19];
        r5_ctl.mode <= r4_ctl.mode;
        r5_ctl.neg  <= r4_ctl.neg;
        r5_ctl.back <= r4_ctl.back;
        r5_tr   <= r4_tr;
        r5_q    <= sq[31:20];
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
            r5_ctl.valid <= 1'b0;
        end else begin
            r2_ctl.valid <= n2_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
            r4_ctl.valid <= r3_ctl.valid;
            r5_ctl.valid <= r4_ctl.valid;
        end
    end

    always_comb begin
        trp = 28'(r3_tv * 16'd5243);
        s   = 17'((r4_m2 + 34'd1638400) >> 17);
        sq  = 34'(s * 17'd41944);
    end

    always_comb begin
        d    = r5_ctl.neg ? -13'(r5_q) : 13'(r5_q);
        trs  = r5_ctl.back ? -13'(r5_tr) : 13'(r5_tr);
        lw   = '0;
        rw   = '0;
        unique case (r5_ctl.mode)
            wdc_pkg::MODE_ROT: begin
                lw = -d;
                rw = d;
            end
            wdc_pkg::MODE_DRIVE: begin
                lw = trs - d;
                rw = trs + d;
            end
            wdc_pkg::MODE_NONE, wdc_pkg::MODE_ARRIVE: begin
                lw = '0;
                rw = '0;
            end
            default: begin
                lw = '0;
                rw = '0;
            end
        endcase
        lsat = lw > 13'sd1023 ? 11'sd1023 : (lw < -13'sd1023 ? -11'sd1023 : lw[10:0]);
        rsat = rw > 13'sd1023 ? 11'sd1023 : (rw < -13'sd1023 ? -11'sd1023 : rw[10:0]);
    end

    always_ff @(posedge i_clk) begin
        o_left_wheel    <= lsat;
        o_right_wheel   <= rsat;
        o_command_valid <= r5_ctl.mode != wdc_pkg::MODE_NONE;
        o_arrived       <= r5_ctl.mode == wdc_pkg::MODE_ARRIVE;
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r5_ctl.valid;
        end
    end
endmodule

[src/waypoint_drive_controller.sv]
// Top level of the waypoint drive controller: config registers, input stage,
// CORDIC cell chain and post-processing. Depends on wdc_pkg, wdc_cordic_cell, wdc_post.
// A pose word is taken in every cycle (o_busy stays low) and its wheel command
// leaves on o_done after one input stage, one cell per CORDIC iteration and
// six arithmetic stages.
// Results cannot be held off; sample them in the o_done cycle.
module waypoint_drive_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    output logic                          o_done,
    input  logic                          i_cfg_we,
    input  logic [wdc_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [wdc_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic signed [15:0]            i_target_x,
    input  logic signed [15:0]            i_target_y,
    input  logic signed [15:0]            i_target_heading,
    input  logic signed [15:0]            i_robot_x,
    input  logic signed [15:0]            i_robot_y,
    input  logic signed [15:0]            i_robot_heading,
    output logic signed [10:0]            o_left_wheel,
    output logic signed [10:0]            o_right_wheel,
    output logic                          o_command_valid,
    output logic                          o_arrived
);
    wdc_pkg::t_cfg  r_cfg;
    wdc_pkg::t_cell r_in;
    wdc_pkg::t_cell n_in;
    wdc_pkg::t_cell chain [wdc_pkg::CORDIC_STAGES+1];
    logic signed [wdc_pkg::DW-1:0] dx, dy;
    logic signed [wdc_pkg::XW-1:0] x0, y0;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_tol     <= 12'd102;
            r_cfg.head_tol    <= 14'd1820;
            r_cfg.aim_tol     <= 14'd8010;
            r_cfg.trans_scale <= 10'd600;
            r_cfg.rot_gain    <= 11'd800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wdc_pkg::CFG_POS_TOL:   r_cfg.pos_tol     <= i_cfg_data[11:0];
                wdc_pkg::CFG_HEAD_TOL:  r_cfg.head_tol    <= i_cfg_data[13:0];
                wdc_pkg::CFG_AIM_TOL:   r_cfg.aim_tol     <= i_cfg_data[13:0];
                wdc_pkg::CFG_TRANS_SCL: r_cfg.trans_scale <= i_cfg_data[9:0];
                wdc_pkg::CFG_ROT_GAIN:  r_cfg.rot_gain    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // error vector and quadrant pre-rotation
    always_comb begin
        dx = 17'(i_target_x) - 17'(i_robot_x);
        dy = 17'(i_target_y) - 17'(i_robot_y);
        x0 = wdc_pkg::XW'($signed({dx, 16'd0}));
        y0 = wdc_pkg::XW'($signed({dy, 16'd0}));
        n_in.valid   = i_start && !o_busy;
        n_in.side.dx = dx;
        n_in.side.dy = dy;
        n_in.side.th = i_target_heading;
        n_in.side.rh = i_robot_heading;
        n_in.x = x0;
        n_in.y = y0;
        n_in.z = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_in.x = y0;
                n_in.y = -x0;
                n_in.z = wdc_pkg::QUARTER_Z;
            end else begin
                n_in.x = -y0;
                n_in.y = x0;
                n_in.z = -wdc_pkg::QUARTER_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in.x    <= n_in.x;
        r_in.y    <= n_in.y;
        r_in.z    <= n_in.z;
        r_in.side <= n_in.side;
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in.valid <= n_in.valid;
        end
    end

    assign chain[0] = r_in;

    for (genvar k = 0; k < wdc_pkg::CORDIC_STAGES; k++) begin : g_cell
        wdc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(k)),
            .i_cell  (chain[k]),
            .o_cell  (chain[k+1])
        );
    end

    wdc_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cell          (chain[wdc_pkg::CORDIC_STAGES]),
        .i_cfg           (r_cfg),
        .o_done          (o_done),
        .o_left_wheel    (o_left_wheel),
        .o_right_wheel   (o_right_wheel),
        .o_command_valid (o_command_valid),
        .o_arrived       (o_arrived)
    );

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, wdc_pkg::LATENCY))
        else $error("result word without matching start");

    a_arrived_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_arrived) |-> (o_command_valid && o_left_wheel == 0 &&
                                   o_right_wheel == 0))
        else $error("arrival word with moving wheels");

    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_command_valid) |-> (!o_arrived && o_left_wheel == 0 &&
                                          o_right_wheel == 0))
        else $error("wheels driven without command");
endmodule
